/* rtl/tstmr_pkg.sv */
package tstmr_pkg;

    // Command codes of the input word
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    // Field widths fixed by the interface
    localparam int SLOT_W = 4;
    localparam int CMD_W  = 2;

    // Status of the slot passing the head of the ring
    typedef struct packed {
        logic hit;          // start/stop addresses this slot
        logic expired;      // tick took this slot to zero
        logic was_running;  // running mark before update
    } head_stat_t;

    // Sequencer states, one-hot
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SWEEP = 3'b010,
        ST_DONE  = 3'b100
    } seq_state_t;

endpackage

/* rtl/tstmr_cell.sv */
module tstmr_cell
    import tstmr_pkg::*;
#(
    parameter int COUNT_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  shift_en,
    input  logic [COUNT_BITS-1:0] count_in,
    input  logic                  run_in,
    output logic [COUNT_BITS-1:0] count_out,
    output logic                  run_out
);

    logic [COUNT_BITS-1:0] count_reg;
    logic                  run_reg;

    // Count carries no reset: it is only looked at while the slot runs
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            count_reg <= count_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
        end else if (shift_en) begin
            run_reg <= run_in;
        end
    end

    assign count_out = count_reg;
    assign run_out   = run_reg;

endmodule

/* rtl/tstmr_head.sv */
module tstmr_head
    import tstmr_pkg::*;
#(
    parameter int COUNT_BITS = 32,
    parameter int IDX_W      = 4
) (
    input  logic [CMD_W-1:0]      cmd,
    input  logic [SLOT_W-1:0]     slot,
    input  logic [IDX_W-1:0]      idx,
    input  logic [COUNT_BITS-1:0] load_count,
    input  logic [COUNT_BITS-1:0] cur_count,
    input  logic                  cur_run,
    output logic [COUNT_BITS-1:0] next_count,
    output logic                  next_run,
    output head_stat_t            stat
);

    localparam logic [COUNT_BITS-1:0] ONE = COUNT_BITS'(1);

    logic [COUNT_BITS-1:0] dec;
    logic                  match;

    assign dec   = cur_count - ONE;
    assign match = (8'(slot) == 8'(idx));

    // Update of the slot at the head; one decrementer shared by all slots
    always_comb begin
        next_count       = cur_count;
        next_run         = cur_run;
        stat.hit         = 1'b0;
        stat.expired     = 1'b0;
        stat.was_running = cur_run;
        unique case (cmd)
            CMD_TICK: begin
                if (cur_run) begin
                    next_count = dec;
                    if (dec == '0) begin
                        next_run     = 1'b0;
                        stat.expired = 1'b1;
                    end
                end
            end
            CMD_START: begin
                if (match) begin
                    stat.hit   = 1'b1;
                    next_count = load_count;
                    next_run   = 1'b1;
                end
            end
            CMD_STOP: begin
                if (match) begin
                    stat.hit = 1'b1;
                    next_run = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

/* rtl/multi_slot_tick_timer_unit.sv */
// Bank of NUM_TIMERS one-shot countdown timers held in a ring of cells that
// rotates past a single update unit. Every command (tick, start, stop, none) turns
// the ring once, one slot per cycle unless a word waits on the result side; an
// item passes through accept, NUM_TIMERS rotation steps and a final word. A
// start or stop yields one acknowledge word; a tick yields one word per expired
// slot in ascending slot order, or one empty word; run_last marks the final
// word of an item.
// A start count of zero is loaded as one. Slots addressed beyond the bank
// are acknowledged with was_running low and change nothing.
module multi_slot_tick_timer_unit
    import tstmr_pkg::*;
#(
    parameter int NUM_TIMERS = 16,
    parameter int COUNT_BITS = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_cmd,
    input  logic [3:0]        s_timer_slot,
    input  logic [31:0]       s_start_count,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_fired,
    output logic [3:0]        m_fired_slot,
    output logic              m_was_running,
    output logic              m_run_last
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam logic [IDX_W-1:0]      LAST_IDX = IDX_W'(NUM_TIMERS - 1);
    localparam logic [COUNT_BITS-1:0] ONE      = COUNT_BITS'(1);

    seq_state_t            state_reg, state_next;
    logic [IDX_W-1:0]      step_reg;
    logic [CMD_W-1:0]      cmd_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic [COUNT_BITS-1:0] cnt_reg;
    logic                  was_reg;
    logic                  pend_valid_reg;
    logic [SLOT_W-1:0]     pend_slot_reg;

    logic                  out_valid_reg;
    logic                  out_fired_reg;
    logic [SLOT_W-1:0]     out_slot_reg;
    logic                  out_was_reg;
    logic                  out_last_reg;

    logic [COUNT_BITS-1:0] ring_count [NUM_TIMERS];
    logic                  ring_run   [NUM_TIMERS];
    logic [COUNT_BITS-1:0] head_count;
    logic                  head_run;
    head_stat_t            head_stat;

    logic                  out_free;
    logic                  push;
    logic                  push_fired;
    logic [SLOT_W-1:0]     push_slot;
    logic                  push_was;
    logic                  push_last;
    logic                  advance;
    logic [COUNT_BITS-1:0] cnt_in;

    // Ring of slot cells; cell 0 is the head, and its update refills the tail
    for (genvar j = 0; j < NUM_TIMERS; j++) begin : g_cell
        logic [COUNT_BITS-1:0] c_in;
        logic                  r_in;
        if (j == NUM_TIMERS - 1) begin : g_tail
            assign c_in = head_count;
            assign r_in = head_run;
        end else begin : g_mid
            assign c_in = ring_count[j+1];
            assign r_in = ring_run[j+1];
        end
        tstmr_cell #(
            .COUNT_BITS(COUNT_BITS)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (advance),
            .count_in (c_in),
            .run_in   (r_in),
            .count_out(ring_count[j]),
            .run_out  (ring_run[j])
        );
    end

    tstmr_head #(
        .COUNT_BITS(COUNT_BITS),
        .IDX_W     (IDX_W)
    ) u_head (
        .cmd       (cmd_reg),
        .slot      (slot_reg),
        .idx       (step_reg),
        .load_count(cnt_reg),
        .cur_count (ring_count[0]),
        .cur_run   (ring_run[0]),
        .next_count(head_count),
        .next_run  (head_run),
        .stat      (head_stat)
    );

    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign cnt_in   = s_start_count[COUNT_BITS-1:0];

    // Word to push and rotation stall
    always_comb begin
        push       = 1'b0;
        push_fired = 1'b0;
        push_slot  = '0;
        push_was   = 1'b0;
        push_last  = 1'b0;
        advance    = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                // an earlier expiry is flushed when a newer one turns up
                if ((cmd_reg == CMD_TICK) && head_stat.expired && pend_valid_reg) begin
                    push       = out_free;
                    push_fired = 1'b1;
                    push_slot  = pend_slot_reg;
                    advance    = out_free;
                end else begin
                    advance = 1'b1;
                end
                if (advance && (step_reg == LAST_IDX)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                push      = out_free;
                push_last = 1'b1;
                if ((cmd_reg == CMD_START) || (cmd_reg == CMD_STOP)) begin
                    push_slot = slot_reg;
                    push_was  = was_reg;
                end else if ((cmd_reg == CMD_TICK) && pend_valid_reg) begin
                    push_fired = 1'b1;
                    push_slot  = pend_slot_reg;
                end
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            pend_valid_reg <= 1'b0;
            was_reg        <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (s_valid && s_ready) begin
                step_reg       <= '0;
                pend_valid_reg <= 1'b0;
                was_reg        <= 1'b0;
            end else if (advance) begin
                step_reg <= (step_reg == LAST_IDX) ? '0 : step_reg + IDX_W'(1);
                if ((cmd_reg == CMD_TICK) && head_stat.expired) begin
                    pend_valid_reg <= 1'b1;
                end
                if (head_stat.hit) begin
                    was_reg <= head_stat.was_running;
                end
            end
        end
    end

    // Captured command and the expiry waiting for its run_last verdict
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg  <= s_cmd;
            slot_reg <= s_timer_slot;
            cnt_reg  <= (cnt_in == '0) ? ONE : cnt_in;
        end
        if (advance && (cmd_reg == CMD_TICK) && head_stat.expired) begin
            pend_slot_reg <= SLOT_W'(step_reg);
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (push) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            out_fired_reg <= push_fired;
            out_slot_reg  <= push_slot;
            out_was_reg   <= push_was;
            out_last_reg  <= push_last;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_fired       = out_fired_reg;
    assign m_fired_slot  = out_slot_reg;
    assign m_was_running = out_was_reg;
    assign m_run_last    = out_last_reg;

endmodule

/* rtl/tstmr_checker.sv */
module tstmr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_fired,
    input logic [3:0]  m_fired_slot,
    input logic        m_was_running,
    input logic        m_run_last
);

    // A stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_fired) &&
            $stable(m_fired_slot) && $stable(m_was_running) && $stable(m_run_last)))
        else $error("result word changed while stalled");

    // Expiry words never claim was_running
    a_fired_was: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_fired) |-> !m_was_running)
        else $error("expiry word with was_running set");

    // Acknowledges and empty words are always the final word of an item
    a_plain_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_fired) |-> m_run_last)
        else $error("non-expiry word without run_last");

    // One item at a time: input closes right after an accept
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input ready straight after accept");

endmodule

bind multi_slot_tick_timer_unit tstmr_checker u_tstmr_checker (.*);
